>>> rtl/cnmf_pkg.sv
// cnmf_pkg: shared types, constants and helper functions of the calendar match finder.
// Depends on nothing; used by every file under rtl.
package cnmf_pkg;

	localparam int unsigned YEARS_AHEAD_DEF = 2;
	localparam int unsigned CFG_W = 60;

	typedef enum logic [2:0] {
		REG_MONTH_MASK    = 3'd0,
		REG_WEEKDAY_MASK  = 3'd1,
		REG_MONTHDAY_MASK = 3'd2,
		REG_HOUR_MASK     = 3'd3,
		REG_MINUTE_MASK   = 3'd4,
		REG_SECOND_MASK   = 3'd5,
		REG_START_STAMP   = 3'd6,
		REG_END_STAMP     = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PRE,
		S_YEAR,
		S_LEAP,
		S_WDAY,
		S_SCAN,
		S_DONE
	} state_t;

	// earliest allowed time on the reference day and on any later day
	typedef struct packed {
		logic       ref_ok;
		logic [4:0] ref_h;
		logic [5:0] ref_m;
		logic [5:0] ref_s;
		logic       gen_ok;
		logic [4:0] gen_h;
		logic [5:0] gen_m;
		logic [5:0] gen_s;
	} time_res_t;

	// index of lowest set bit, 0 when none
	function automatic logic [5:0] first_set(input logic [63:0] v);
		logic [5:0] r;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			if (v[i]) r = i[5:0];
		end
		return r;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] mo, input logic leap);
		logic [4:0] r;
		case (mo)
			4'd2: r = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
			default: r = 5'd31;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/cnmf_time.sv
// cnmf_time: earliest allowed hour/minute/second from the time masks.
// Depends on cnmf_pkg (time_res_t, first_set).
module cnmf_time (
	input  logic [23:0]          hour_mask,
	input  logic [59:0]          minute_mask,
	input  logic [59:0]          second_mask,
	input  logic [4:0]           rh,
	input  logic [5:0]           rm,
	input  logic [5:0]           rs,
	output cnmf_pkg::time_res_t  res
);

	logic [63:0] hr_ext, min_ext, sec_ext;
	logic [63:0] sec_from, min_gt, hr_gt;
	logic        hr_ok, min_ok, has_ms, a_ok, b_ok, c_ok;
	logic [5:0]  fm0, fs0, fh_gen, fh_gt, fm_gt, fs_from;
	logic [6:0]  rm_p1;
	logic [5:0]  rh_p1;

	assign hr_ext  = {40'b0, hour_mask};
	assign min_ext = {4'b0, minute_mask};
	assign sec_ext = {4'b0, second_mask};
	assign rm_p1   = {1'b0, rm} + 7'd1;
	assign rh_p1   = {1'b0, rh} + 6'd1;

	assign hr_ok    = hr_ext[{1'b0, rh}];
	assign min_ok   = min_ext[rm];
	assign sec_from = sec_ext & ({64{1'b1}} << rs);
	assign min_gt   = min_ext & ({64{1'b1}} << rm_p1);
	assign hr_gt    = hr_ext & ({64{1'b1}} << rh_p1);
	assign has_ms   = (|minute_mask) && (|second_mask);

	assign fm0     = cnmf_pkg::first_set(min_ext);
	assign fs0     = cnmf_pkg::first_set(sec_ext);
	assign fh_gen  = cnmf_pkg::first_set(hr_ext);
	assign fh_gt   = cnmf_pkg::first_set(hr_gt);
	assign fm_gt   = cnmf_pkg::first_set(min_gt);
	assign fs_from = cnmf_pkg::first_set(sec_from);

	// same hour and minute, later minute in same hour, or a later hour
	assign a_ok = hr_ok && min_ok && (|sec_from);
	assign b_ok = hr_ok && (|min_gt) && (|second_mask);
	assign c_ok = (|hr_gt) && has_ms;

	always_comb begin
		res.gen_ok = (|hour_mask) && has_ms;
		res.gen_h  = fh_gen[4:0];
		res.gen_m  = fm0;
		res.gen_s  = fs0;
		res.ref_ok = a_ok || b_ok || c_ok;
		if (a_ok) begin
			res.ref_h = rh;
			res.ref_m = rm;
			res.ref_s = fs_from;
		end else if (b_ok) begin
			res.ref_h = rh;
			res.ref_m = fm_gt;
			res.ref_s = fs0;
		end else begin
			res.ref_h = fh_gt[4:0];
			res.ref_m = fm0;
			res.ref_s = fs0;
		end
	end

endmodule

>>> rtl/calendar_next_match_finder.sv
// calendar_next_match_finder: next calendar moment allowed by the schedule masks.
// Depends on cnmf_pkg and cnmf_time.
//
//  channel | direction | handshake          | word
//  in      | input     | in_valid/in_stall  | now_year..now_second
//  out     | output    | out_valid/out_stall| found, run_year..run_second
//  cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// The day scanner tests one (month, day) slot per cycle, 31 slots per month;
// before each year the S_YEAR, S_LEAP and S_WDAY states do the leap and Jan 1
// weekday arithmetic.
// A hit ends the scan early. in_stall is high from accept until the result is taken.
// arst_n clears the masks to all allowed, start to 0 and end to all ones.
module calendar_next_match_finder #(
	parameter int unsigned YEARS_AHEAD = cnmf_pkg::YEARS_AHEAD_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [2:0]                 cfg_index,
	input  logic [cnmf_pkg::CFG_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [11:0]                now_year,
	input  logic [3:0]                 now_month,
	input  logic [4:0]                 now_day,
	input  logic [4:0]                 now_hour,
	input  logic [5:0]                 now_minute,
	input  logic [5:0]                 now_second,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       found,
	output logic [11:0]                run_year,
	output logic [3:0]                 run_month,
	output logic [4:0]                 run_day,
	output logic [4:0]                 run_hour,
	output logic [5:0]                 run_minute,
	output logic [5:0]                 run_second
);

	logic [11:0] month_mask_q;
	logic [6:0]  weekday_mask_q;
	logic [30:0] monthday_mask_q;
	logic [23:0] hour_mask_q;
	logic [59:0] minute_mask_q, second_mask_q;
	logic [37:0] start_q, end_q;

	cnmf_pkg::state_t state_q, state_d;

	logic [37:0] ref_q;
	logic [11:0] y_q, ylast_q;
	logic [3:0]  mo_q;
	logic [4:0]  d_q;
	logic [2:0]  wd_q;
	logic        leap_q;
	logic [12:0] yy_q;
	logic [12:0] q1_q, qy_q;
	logic [12:0] sum_q;
	cnmf_pkg::time_res_t tres, tres_q;

	logic [37:0] now_pk;
	logic [11:0] ry;
	logic [20:0] ref_key, cand_key;
	logic        in_acc;
	logic        day_in_month, date_ok, is_ref, time_ok, hit, last_slot;
	logic [4:0]  hh;
	logic [5:0]  mm, ss;
	logic [37:0] stamp;
	logic [12:0] ylast_sum, yy_next, r100, leap_q100;
	logic [26:0] prod_wd;
	logic [3:0]  r7;
	logic [2:0]  dow;
	logic [31:0] prod_yy, prod_y;

	// ---------------- configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			month_mask_q    <= '1;
			weekday_mask_q  <= '1;
			monthday_mask_q <= '1;
			hour_mask_q     <= '1;
			minute_mask_q   <= '1;
			second_mask_q   <= '1;
			start_q         <= '0;
			end_q           <= '1;
		end else if (cfg_we) begin
			case (cnmf_pkg::reg_idx_t'(cfg_index))
				cnmf_pkg::REG_MONTH_MASK:    month_mask_q    <= cfg_data[11:0];
				cnmf_pkg::REG_WEEKDAY_MASK:  weekday_mask_q  <= cfg_data[6:0];
				cnmf_pkg::REG_MONTHDAY_MASK: monthday_mask_q <= cfg_data[30:0];
				cnmf_pkg::REG_HOUR_MASK:     hour_mask_q     <= cfg_data[23:0];
				cnmf_pkg::REG_MINUTE_MASK:   minute_mask_q   <= cfg_data[59:0];
				cnmf_pkg::REG_SECOND_MASK:   second_mask_q   <= cfg_data[59:0];
				cnmf_pkg::REG_START_STAMP:   start_q         <= cfg_data[37:0];
				cnmf_pkg::REG_END_STAMP:     end_q           <= cfg_data[37:0];
				default: ;
			endcase
		end
	end

	// ---------------- time unit
	cnmf_time u_time (
		.hour_mask   (hour_mask_q),
		.minute_mask (minute_mask_q),
		.second_mask (second_mask_q),
		.rh          (ref_q[16:12]),
		.rm          (ref_q[11:6]),
		.rs          (ref_q[5:0]),
		.res         (tres)
	);

	// ---------------- day scan combinational
	assign now_pk  = {now_year, now_month, now_day, now_hour, now_minute, now_second};
	assign ry      = ref_q[37:26];
	assign ref_key = ref_q[37:17];
	assign cand_key = {y_q, mo_q, d_q};

	assign day_in_month = d_q <= cnmf_pkg::month_len(mo_q, leap_q);
	assign date_ok = day_in_month && month_mask_q[mo_q - 4'd1]
		&& monthday_mask_q[d_q - 5'd1] && weekday_mask_q[wd_q]
		&& (cand_key >= ref_key);
	assign is_ref  = cand_key == ref_key;
	assign time_ok = is_ref ? tres_q.ref_ok : tres_q.gen_ok;
	assign hit     = date_ok && time_ok;
	assign hh      = is_ref ? tres_q.ref_h : tres_q.gen_h;
	assign mm      = is_ref ? tres_q.ref_m : tres_q.gen_m;
	assign ss      = is_ref ? tres_q.ref_s : tres_q.gen_s;
	assign stamp   = {y_q, mo_q, d_q, hh, mm, ss};
	assign last_slot = (mo_q == 4'd12) && (d_q == 5'd31);

	assign ylast_sum = {1'b0, ry} + 13'(YEARS_AHEAD);
	assign yy_next   = {1'b0, y_q} + 13'd399;

	// x/100 as multiply by 5243 >> 19, exact below 43690
	assign prod_yy = 32'(yy_next) * 32'd5243;
	assign prod_y  = 32'({1'b0, y_q}) * 32'd5243;
	assign r100    = {1'b0, y_q} - 13'(qy_q * 13'd100);
	assign leap_q100 = qy_q;

	// s mod 7: q = s*9362 >> 16 is floor or one less
	assign prod_wd = 27'(sum_q) * 27'd9362;
	assign r7  = 4'(sum_q - 13'(prod_wd[26:16]) * 13'd7);
	assign dow = (r7 >= 4'd7) ? 3'(r7 - 4'd7) : r7[2:0];

	assign in_acc  = in_valid && !in_stall;

	// ---------------- sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			cnmf_pkg::S_IDLE: if (in_valid) state_d = cnmf_pkg::S_PRE;
			cnmf_pkg::S_PRE:  state_d = cnmf_pkg::S_YEAR;
			cnmf_pkg::S_YEAR: state_d = cnmf_pkg::S_LEAP;
			cnmf_pkg::S_LEAP: state_d = cnmf_pkg::S_WDAY;
			cnmf_pkg::S_WDAY: state_d = cnmf_pkg::S_SCAN;
			cnmf_pkg::S_SCAN: begin
				if (hit) state_d = cnmf_pkg::S_DONE;
				else if (last_slot)
					state_d = (y_q == ylast_q) ? cnmf_pkg::S_DONE : cnmf_pkg::S_YEAR;
			end
			cnmf_pkg::S_DONE: if (!out_stall) state_d = cnmf_pkg::S_IDLE;
			default: state_d = cnmf_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = state_q != cnmf_pkg::S_IDLE;
		out_valid = state_q == cnmf_pkg::S_DONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= cnmf_pkg::S_IDLE;
		else         state_q <= state_d;
	end

	// ---------------- datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ref_q <= (start_q > now_pk) ? start_q : now_pk;
		end
		case (state_q)
			cnmf_pkg::S_PRE: begin
				tres_q  <= tres;
				y_q     <= ry;
				ylast_q <= ylast_sum[12] ? 12'hFFF : ylast_sum[11:0];
				mo_q    <= 4'd1;
				d_q     <= 5'd1;
				found      <= 1'b0;
				run_year   <= '0;
				run_month  <= '0;
				run_day    <= '0;
				run_hour   <= '0;
				run_minute <= '0;
				run_second <= '0;
			end
			cnmf_pkg::S_YEAR: begin
				yy_q <= yy_next;
				q1_q <= 13'(prod_yy >> 19);
				qy_q <= 13'(prod_y >> 19);
			end
			cnmf_pkg::S_LEAP: begin
				leap_q <= ((y_q[1:0] == 2'd0) && (r100 != 13'd0))
					|| ((r100 == 13'd0) && (leap_q100[1:0] == 2'd0));
				// Jan 1 weekday sum, Sunday = 0
				sum_q  <= yy_q + (yy_q >> 2) - q1_q + (q1_q >> 2) + 13'd1;
			end
			cnmf_pkg::S_WDAY: begin
				wd_q <= (dow == 3'd0) ? 3'd6 : dow - 3'd1;
			end
			cnmf_pkg::S_SCAN: begin
				if (hit) begin
					if (stamp <= end_q) begin
						found      <= 1'b1;
						run_year   <= y_q;
						run_month  <= mo_q;
						run_day    <= d_q;
						run_hour   <= hh;
						run_minute <= mm;
						run_second <= ss;
					end
				end else begin
					if (day_in_month) wd_q <= (wd_q == 3'd6) ? 3'd0 : wd_q + 3'd1;
					if (d_q == 5'd31) begin
						d_q <= 5'd1;
						if (mo_q == 4'd12) begin
							mo_q <= 4'd1;
							if (y_q != ylast_q) y_q <= y_q + 12'd1;
						end else begin
							mo_q <= mo_q + 4'd1;
						end
					end else begin
						d_q <= d_q + 5'd1;
					end
				end
			end
			default: ;
		endcase
	end

endmodule

>>> test/calendar_next_match_finder_tb.sv
// calendar_next_match_finder_tb: self-checking bench for the next-match finder.
// Depends on cnmf_pkg and the calendar_next_match_finder RTL; a local predictor
// computes words of untyped rows; directed table first, then randomized phases.
module calendar_next_match_finder_tb;

	localparam int YEARS_AHEAD = int'(cnmf_pkg::YEARS_AHEAD_DEF);
	localparam int CYCLE_LIMIT = 5000000;

	typedef struct packed {
		logic [11:0] y;
		logic [3:0]  mo;
		logic [4:0]  d;
		logic [4:0]  h;
		logic [5:0]  mi;
		logic [5:0]  s;
	} moment_t;

	typedef struct packed {
		logic    found;
		moment_t at;
	} sched_t;

	typedef struct packed {
		moment_t now;
		logic    typed;
		sched_t  want;
	} row_t;

	localparam sched_t NONE = '0;
	localparam row_t DIRECTED [12] = '{
		'{'{12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}, 1'b1,
			'{1'b1, '{12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}}},
		'{'{12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}, 1'b1,
			'{1'b1, '{12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}}},
		'{'{12'd2399, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59}, 1'b1,
			'{1'b1, '{12'd2399, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59}}},
		'{'{12'd4095, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59}, 1'b1,
			'{1'b1, '{12'd4095, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59}}},
		'{'{12'd4095, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63}, 1'b1, NONE},
		// month 0 / day 0: whole year qualifies, not the reference day
		'{'{12'd2001, 4'd0, 5'd0, 5'd12, 6'd0, 6'd0}, 1'b1,
			'{1'b1, '{12'd2001, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}}},
		// hour 24 leaves nothing on the reference day
		'{'{12'd2000, 4'd3, 5'd5, 5'd24, 6'd0, 6'd0}, 1'b1,
			'{1'b1, '{12'd2000, 4'd3, 5'd6, 5'd0, 6'd0, 6'd0}}},
		// Feb 30 does not exist
		'{'{12'd2001, 4'd2, 5'd30, 5'd10, 6'd0, 6'd0}, 1'b1,
			'{1'b1, '{12'd2001, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0}}},
		'{'{12'd2000, 4'd2, 5'd29, 5'd23, 6'd59, 6'd63}, 1'b1,
			'{1'b1, '{12'd2000, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0}}},
		'{'{12'd2100, 4'd2, 5'd29, 5'd5, 6'd6, 6'd7}, 1'b0, NONE},
		'{'{12'd2047, 4'd6, 5'd15, 5'd12, 6'd30, 6'd30}, 1'b0, NONE},
		'{'{12'd2048, 4'd9, 5'd17, 5'd21, 6'd42, 6'd21}, 1'b0, NONE}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	cnmf_pkg::reg_idx_t cfg_index;
	logic [cnmf_pkg::CFG_W-1:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [11:0] now_year;
	logic [3:0]  now_month;
	logic [4:0]  now_day;
	logic [4:0]  now_hour;
	logic [5:0]  now_minute;
	logic [5:0]  now_second;
	logic        out_valid;
	logic        out_stall;
	logic        found;
	logic [11:0] run_year;
	logic [3:0]  run_month;
	logic [4:0]  run_day;
	logic [4:0]  run_hour;
	logic [5:0]  run_minute;
	logic [5:0]  run_second;

	// schedule registers as the finder should hold them
	logic [11:0] sch_month;
	logic [6:0]  sch_wday;
	logic [30:0] sch_mday;
	logic [23:0] sch_hour;
	logic [59:0] sch_min;
	logic [59:0] sch_sec;
	logic [37:0] sch_start;
	logic [37:0] sch_end;

	sched_t runs_due [$];
	int     mismatches = 0;
	int     cycles = 0;
	int     snd_pct = 0;
	int     rcv_pct = 0;

	calendar_next_match_finder dut (.*);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic int lowest_from(logic [59:0] m, int from, int w);
		for (int i = from; i < w; i++)
			if (m[i]) return i;
		return -1;
	endfunction

	// earliest allowed time not before rh:rm:rs
	function automatic bit earliest_time(int rh, int rm, int rs,
			output int oh, output int om, output int os);
		int m, s;
		oh = 0; om = 0; os = 0;
		for (int h = rh; h < 24; h++) begin
			if (!sch_hour[h]) continue;
			if (h > rh) begin
				m = lowest_from(sch_min, 0, 60);
				s = lowest_from(sch_sec, 0, 60);
				if (m >= 0 && s >= 0) begin
					oh = h; om = m; os = s;
					return 1'b1;
				end
				continue;
			end
			for (int mi = rm; mi < 60; mi++) begin
				if (!sch_min[mi]) continue;
				s = lowest_from(sch_sec, mi > rm ? 0 : rs, 60);
				if (s >= 0) begin
					oh = h; om = mi; os = s;
					return 1'b1;
				end
			end
		end
		return 1'b0;
	endfunction

	function automatic sched_t next_run(moment_t now);
		moment_t rf;
		sched_t  r;
		logic [37:0] stamp;
		int ylast, len, yy, dow, h, mi, s, rkey, key;
		bit ok;
		r = '0;
		rf = (sch_start > now) ? moment_t'(sch_start) : now;
		rkey = (int'(rf.y) << 9) | (int'(rf.mo) << 5) | int'(rf.d);
		ylast = int'(rf.y) + YEARS_AHEAD;
		if (ylast > 4095) ylast = 4095;
		for (int y = rf.y; y <= ylast; y++) begin
			for (int mo = 1; mo <= 12; mo++) begin
				if (!sch_month[mo-1]) continue;
				case (mo)
					2: len = ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0) ? 29 : 28;
					4, 6, 9, 11: len = 30;
					default: len = 31;
				endcase
				for (int d = 1; d <= len; d++) begin
					if (!sch_mday[d-1]) continue;
					key = (y << 9) | (mo << 5) | d;
					if (key < rkey) continue;
					// Sakamoto weekday, shifted so Monday is bit 0
					yy = y + 400 - (mo < 3 ? 1 : 0);
					dow = yy + yy / 4 - yy / 100 + yy / 400 + d;
					case (mo)
						1, 5: dow += 0;
						2, 6: dow += 3;
						3, 11: dow += 2;
						4: dow += 5;
						7: dow += 5;
						8: dow += 1;
						9, 12: dow += 4;
						default: dow += 6;
					endcase
					if (!sch_wday[(dow % 7 + 6) % 7]) continue;
					if (key == rkey) ok = earliest_time(rf.h, rf.mi, rf.s, h, mi, s);
					else ok = earliest_time(0, 0, 0, h, mi, s);
					if (!ok) continue;
					stamp = {y[11:0], mo[3:0], d[4:0], h[4:0], mi[5:0], s[5:0]};
					if (stamp > sch_end) return r;
					r.found = 1'b1;
					r.at = stamp;
					return r;
				end
			end
		end
		return r;
	endfunction

	task automatic report(string what, sched_t want, sched_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t %s: want %b %0d-%0d-%0d %0d:%0d:%0d got %b %0d-%0d-%0d %0d:%0d:%0d",
				$realtime, what, want.found, want.at.y, want.at.mo, want.at.d, want.at.h,
				want.at.mi, want.at.s, got.found, got.at.y, got.at.mo, got.at.d, got.at.h,
				got.at.mi, got.at.s);
	endtask

	// result side: random stall and check of every taken word
	always @(posedge clk) begin
		sched_t got, want;
		out_stall <= ($urandom_range(99) < rcv_pct);
		if (arst_n && out_valid && !out_stall) begin
			got = {found, run_year, run_month, run_day, run_hour, run_minute, run_second};
			if (runs_due.size() == 0) begin
				report("unexpected word", NONE, got);
			end else begin
				want = runs_due.pop_front();
				if (got !== want) report("mismatch", want, got);
			end
		end
	end

	// leaves cfg_we high; the caller lowers it after the last write
	task automatic write_reg(cnmf_pkg::reg_idx_t idx, logic [59:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			cnmf_pkg::REG_MONTH_MASK:    sch_month = val[11:0];
			cnmf_pkg::REG_WEEKDAY_MASK:  sch_wday = val[6:0];
			cnmf_pkg::REG_MONTHDAY_MASK: sch_mday = val[30:0];
			cnmf_pkg::REG_HOUR_MASK:     sch_hour = val[23:0];
			cnmf_pkg::REG_MINUTE_MASK:   sch_min = val;
			cnmf_pkg::REG_SECOND_MASK:   sch_sec = val;
			cnmf_pkg::REG_START_STAMP:   sch_start = val[37:0];
			default:                     sch_end = val[37:0];
		endcase
	endtask

	task automatic send(moment_t now, bit typed, sched_t want);
		while ($urandom_range(99) < snd_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		{now_year, now_month, now_day, now_hour, now_minute, now_second} <= now;
		do @(posedge clk); while (in_stall);
		runs_due.push_back(typed ? want : next_run(now));
	endtask

	function automatic logic [59:0] rand_mask(int w);
		logic [59:0] m;
		m = 60'({$urandom, $urandom});
		case ($urandom_range(9))
			0: m = '0;
			1, 2: m = '1;
			3: m = 60'd1 << $urandom_range(w - 1);
			4: m = m & 60'({$urandom, $urandom});
			default: ;
		endcase
		return m & ((60'd1 << w) - 1);
	endfunction

	function automatic moment_t rand_moment();
		moment_t t;
		t = 38'({$urandom, $urandom});
		if ($urandom_range(9) != 0) begin
			t.y = 12'($urandom_range(2399, 1970));
			t.mo = 4'($urandom_range(12, 1));
			t.d = 5'($urandom_range(31, 1));
			t.h = 5'($urandom_range(23));
			t.mi = 6'($urandom_range(59));
			t.s = 6'($urandom_range(59));
		end
		return t;
	endfunction

	initial begin
		logic [59:0] val [8];
		int n;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= cnmf_pkg::REG_MONTH_MASK;
		cfg_data <= '0;
		in_valid <= 1'b0;
		{now_year, now_month, now_day, now_hour, now_minute, now_second} <= '0;
		sch_month = '1; sch_wday = '1; sch_mday = '1; sch_hour = '1;
		sch_min = '1; sch_sec = '1; sch_start = '0; sch_end = '1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		snd_pct = 33; rcv_pct = 61;
		foreach (DIRECTED[i]) send(DIRECTED[i].now, DIRECTED[i].typed, DIRECTED[i].want);

		for (int p = 0; p < 24; p++) begin
			in_valid <= 1'b0;
			while (runs_due.size() != 0) @(posedge clk);
			repeat (4) @(posedge clk);
			case (p / 8)
				0: begin snd_pct = 33; rcv_pct = 61; end
				1: begin snd_pct = 61; rcv_pct = 33; end
				default: begin snd_pct = 0; rcv_pct = 0; end
			endcase
			val = '{60'hFFF, 60'h7F, 60'h7FFF_FFFF, 60'hFF_FFFF, '1, '1, '0, 60'h3F_FFFF_FFFF};
			if (p < 8) begin
				// one register at its hard extreme, the rest at reset values
				if (p == 6) val[6] = 60'h3F_FFFF_FFFF;
				else val[p] = '0;
				n = 6;
			end else begin
				val[0] = rand_mask(12);
				val[1] = rand_mask(7);
				val[2] = rand_mask(31);
				val[3] = rand_mask(24);
				val[4] = rand_mask(60);
				val[5] = rand_mask(60);
				if ($urandom_range(2) == 0) val[6] = rand_moment();
				if ($urandom_range(2) == 0) val[7] = rand_moment();
				n = 30;
			end
			for (int r = 0; r < 8; r++) write_reg(cnmf_pkg::reg_idx_t'(r), val[r]);
			cfg_we <= 1'b0;
			for (int k = 0; k < n; k++) send(rand_moment(), 1'b0, NONE);
		end

		in_valid <= 1'b0;
		while (runs_due.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> calendar_next_match_finder.f
rtl/cnmf_pkg.sv
rtl/cnmf_time.sv
rtl/calendar_next_match_finder.sv
test/calendar_next_match_finder_tb.sv
